### rtl/sdm_pkg.sv
package sdm_pkg;

    // Default operand width in bits.
    localparam int WORD_BITS_DEF = 64;

    // Width of every data port of the block.
    localparam int PORT_BITS = 64;

    // Side information that travels down the pipeline next to each request.
    typedef struct packed {
        logic valid;     // The stage holds a live request.
        logic a_neg;     // The dividend is negative.
        logic b_neg;     // The divisor is negative.
        logic div_zero;  // The divisor is zero.
    } ctl_t;

endpackage

### rtl/sdm_div_step.sv
module sdm_div_step #(
    parameter int WORD_BITS = sdm_pkg::WORD_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 advance,
    input  sdm_pkg::ctl_t        ctl_in,
    input  logic [WORD_BITS-1:0] rem_in,
    input  logic [WORD_BITS-1:0] num_in,
    input  logic [WORD_BITS-1:0] den_in,
    input  logic [WORD_BITS-1:0] b_in,
    output sdm_pkg::ctl_t        ctl_out,
    output logic [WORD_BITS-1:0] rem_out,
    output logic [WORD_BITS-1:0] num_out,
    output logic [WORD_BITS-1:0] den_out,
    output logic [WORD_BITS-1:0] b_out
);

    sdm_pkg::ctl_t        ctl_reg;
    logic [WORD_BITS-1:0] rem_reg;
    logic [WORD_BITS-1:0] num_reg;
    logic [WORD_BITS-1:0] den_reg;
    logic [WORD_BITS-1:0] b_reg;

    logic [WORD_BITS:0]   shifted;
    logic [WORD_BITS:0]   diff;
    logic                 fits;
    logic [WORD_BITS-1:0] rem_next;
    logic [WORD_BITS-1:0] num_next;

    // One restoring step: bring down the next dividend bit and try the subtraction.
    // The quotient bit shifts in at the bottom as the dividend bits leave the top.
    always_comb
    begin
        shifted  = {rem_in, num_in[WORD_BITS-1]};
        diff     = shifted - {1'b0, den_in};
        fits     = ~diff[WORD_BITS];
        rem_next = fits ? diff[WORD_BITS-1:0] : shifted[WORD_BITS-1:0];
        num_next = {num_in[WORD_BITS-2:0], fits};
    end

    // Control state of the stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (advance)
        begin
            ctl_reg <= ctl_in;
        end
    end

    // Data of the stage, loaded whenever the pipeline moves.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rem_reg <= rem_next;
            num_reg <= num_next;
            den_reg <= den_in;
            b_reg   <= b_in;
        end
    end

    assign ctl_out = ctl_reg;
    assign rem_out = rem_reg;
    assign num_out = num_reg;
    assign den_out = den_reg;
    assign b_out   = b_reg;

endmodule

### rtl/signed_64bit_divider_modulo.sv
// Pipelined signed divider. Each request gives a quotient truncated toward
// zero, a remainder with the sign of the dividend and a floored modulo with
// the sign of the divisor; only the low WORD_BITS bits of each operand are
// used and every result is sign-extended to 64 bits. A new request is taken
// in every cycle while the pipeline moves; each passes one stage that forms
// the operand magnitudes, WORD_BITS stages that each produce one quotient
// bit with a restoring subtraction, and one stage that applies the signs
// and registers the results. The whole pipeline holds while a result waits
// to be taken. A zero divisor raises divide_by_zero; the quotient is then
// all ones for a non-negative dividend and one for a negative dividend, and
// the remainder and modulo both equal the dividend.
module signed_64bit_divider_modulo #(
    parameter int WORD_BITS = sdm_pkg::WORD_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [sdm_pkg::PORT_BITS-1:0]  dividend,
    input  logic signed [sdm_pkg::PORT_BITS-1:0]  divisor,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [sdm_pkg::PORT_BITS-1:0]  quotient,
    output logic signed [sdm_pkg::PORT_BITS-1:0]  remainder,
    output logic signed [sdm_pkg::PORT_BITS-1:0]  modulo,
    output logic                                  divide_by_zero
);

    logic advance;

    // Pipeline taps: index 0 is the entry stage, index k+1 follows step k.
    sdm_pkg::ctl_t        ctl_pipe [0:WORD_BITS];
    logic [WORD_BITS-1:0] rem_pipe [0:WORD_BITS];
    logic [WORD_BITS-1:0] num_pipe [0:WORD_BITS];
    logic [WORD_BITS-1:0] den_pipe [0:WORD_BITS];
    logic [WORD_BITS-1:0] b_pipe   [0:WORD_BITS];

    // Entry stage registers.
    sdm_pkg::ctl_t        ctl0_reg;
    sdm_pkg::ctl_t        ctl0_next;
    logic [WORD_BITS-1:0] num0_reg;
    logic [WORD_BITS-1:0] num0_next;
    logic [WORD_BITS-1:0] den0_reg;
    logic [WORD_BITS-1:0] den0_next;
    logic [WORD_BITS-1:0] b0_reg;
    logic [WORD_BITS-1:0] a_word;
    logic [WORD_BITS-1:0] b_word;

    // Output stage registers.
    logic                        out_valid_reg;
    logic                        dz_reg;
    logic signed [WORD_BITS-1:0] quo_reg;
    logic signed [WORD_BITS-1:0] quo_next;
    logic signed [WORD_BITS-1:0] rem_reg;
    logic signed [WORD_BITS-1:0] rem_next;
    logic signed [WORD_BITS-1:0] mod_reg;
    logic signed [WORD_BITS-1:0] mod_next;
    logic [WORD_BITS-1:0]        q_fin;
    logic [WORD_BITS-1:0]        r_fin;
    sdm_pkg::ctl_t               ctl_fin;

    // The whole pipeline moves unless a finished result is waiting.
    assign advance  = ~out_valid_reg | out_ready;
    assign in_ready = advance;

    // Entry stage: sign flags and operand magnitudes.
    always_comb
    begin
        a_word             = dividend[WORD_BITS-1:0];
        b_word             = divisor[WORD_BITS-1:0];
        ctl0_next.valid    = in_valid;
        ctl0_next.a_neg    = a_word[WORD_BITS-1];
        ctl0_next.b_neg    = b_word[WORD_BITS-1];
        num0_next          = a_word[WORD_BITS-1] ? (~a_word + 1'b1) : a_word;
        den0_next          = b_word[WORD_BITS-1] ? (~b_word + 1'b1) : b_word;
        ctl0_next.div_zero = (b_word == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl0_reg <= '0;
        end
        else if (advance)
        begin
            ctl0_reg <= ctl0_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            num0_reg <= num0_next;
            den0_reg <= den0_next;
            b0_reg   <= b_word;
        end
    end

    assign ctl_pipe[0] = ctl0_reg;
    assign rem_pipe[0] = '0;
    assign num_pipe[0] = num0_reg;
    assign den_pipe[0] = den0_reg;
    assign b_pipe[0]   = b0_reg;

    // One restoring division step per stage.
    for (genvar k = 0; k < WORD_BITS; k++)
    begin : g_step
        sdm_div_step #(
            .WORD_BITS(WORD_BITS)
        ) u_step (
            .clk    (clk),
            .rst_n  (rst_n),
            .advance(advance),
            .ctl_in (ctl_pipe[k]),
            .rem_in (rem_pipe[k]),
            .num_in (num_pipe[k]),
            .den_in (den_pipe[k]),
            .b_in   (b_pipe[k]),
            .ctl_out(ctl_pipe[k+1]),
            .rem_out(rem_pipe[k+1]),
            .num_out(num_pipe[k+1]),
            .den_out(den_pipe[k+1]),
            .b_out  (b_pipe[k+1])
        );
    end

    // Sign fix-up of quotient and remainder, and selection of the floored modulo.
    always_comb
    begin
        ctl_fin  = ctl_pipe[WORD_BITS];
        q_fin    = num_pipe[WORD_BITS];
        r_fin    = rem_pipe[WORD_BITS];
        quo_next = (ctl_fin.a_neg != ctl_fin.b_neg) ? (~q_fin + 1'b1) : q_fin;
        rem_next = ctl_fin.a_neg ? (~r_fin + 1'b1) : r_fin;
        if (r_fin == '0)
        begin
            mod_next = '0;
        end
        else if (ctl_fin.a_neg && ctl_fin.b_neg)
        begin
            mod_next = ~r_fin + 1'b1;
        end
        else if (ctl_fin.a_neg)
        begin
            mod_next = b_pipe[WORD_BITS] - r_fin;
        end
        else if (ctl_fin.b_neg)
        begin
            mod_next = b_pipe[WORD_BITS] + r_fin;
        end
        else
        begin
            mod_next = r_fin;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= ctl_fin.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
            mod_reg <= mod_next;
            dz_reg  <= ctl_fin.div_zero;
        end
    end

    // Results are sign-extended to the port width.
    assign out_valid      = out_valid_reg;
    assign quotient       = sdm_pkg::PORT_BITS'(quo_reg);
    assign remainder      = sdm_pkg::PORT_BITS'(rem_reg);
    assign modulo         = sdm_pkg::PORT_BITS'(mod_reg);
    assign divide_by_zero = dz_reg;

`ifndef SYNTHESIS
    // After the last step the partial remainder is below the divisor magnitude.
    a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl_fin.valid && !ctl_fin.div_zero) |-> (r_fin < den_pipe[WORD_BITS]))
        else $error("final partial remainder not below divisor");

    // An exact division gives a zero modulo.
    a_exact_mod_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && remainder == '0) |-> (modulo == '0))
        else $error("modulo non-zero for exact division");

    // A zero divisor leaves remainder and modulo equal to the dividend.
    a_dz_rem_mod: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && divide_by_zero) |-> (remainder == modulo))
        else $error("remainder and modulo differ for zero divisor");

    // A zero divisor with a non-negative dividend gives an all-ones quotient.
    a_dz_quotient: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && divide_by_zero && !remainder[sdm_pkg::PORT_BITS-1])
            |-> (quotient == '1))
        else $error("quotient not all ones for zero divisor");
`endif

endmodule
